// ===== rtl/core/bitc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitc_pkg
// Shared types, constants and helpers for the binned interval tag counter.
// ----------------------------------------------------------------------------
package bitc_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_W      = 10;
   localparam int COORD_W     = 31;
   localparam int SEQ_W       = 8;
   localparam int CNT32_W     = 32;
   localparam int BW_W        = 21;
   localparam int NCELL       = 8;
   localparam int CELL_W      = $clog2(NCELL);
   localparam int BANK_DEPTH  = TABLE_DEPTH / NCELL;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);
   localparam int STEP_W      = BANK_AW + 1;
   localparam int CSR_AW      = 2;
   localparam int CSR_DW      = 32;

   localparam logic [BW_W-1:0]    BW_RESET = BW_W'(10000);
   localparam logic [CNT32_W-1:0] SAT32    = {CNT32_W{1'b1}};

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_COUNT = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [SEQ_W-1:0]   chrom;
      logic [COORD_W-1:0] start_req;
      logic [COORD_W-1:0] stop;
      logic [SLOT_W-1:0]  slot;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  hit_slot;
      logic [CNT32_W-1:0] region_count;
      logic [CNT32_W-1:0] tag_total;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [COORD_W-1:0] first;
      logic [COORD_W-1:0] last;
   } region_type;

   typedef struct packed {
      logic               valid;
      logic [CNT32_W-1:0] hits;
   } count_type;

   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] first;
      logic [COORD_W-1:0] last;
      logic [SLOT_W-1:0]  slot;
      logic [CNT32_W-1:0] hits;
   } best_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   chrom;
      logic [COORD_W-1:0] c;
      logic [COORD_W-1:0] lo;
      logic [COORD_W+1:0] hi;
   } query_type;

   typedef struct packed {
      logic               wr_region;
      logic               wr_count;
      logic               wr_all;
      logic [CELL_W-1:0]  wcell;
      logic [BANK_AW-1:0] waddr;
      region_type         region_wdata;
      count_type          count_wdata;
      logic               rd_en;
      logic [BANK_AW-1:0] raddr;
      logic               clr_best;
      logic               shift;
   } ctl_type;

   function automatic best_type pick(input best_type a, input best_type b);
      best_type r;
      if (!a.found) begin
         r = b;
      end else if (!b.found) begin
         r = a;
      end else if ({a.first, a.last, a.slot} <= {b.first, b.last, b.slot}) begin
         r = a;
      end else begin
         r = b;
      end
      return r;
   endfunction

   function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
      return (v == SAT32) ? v : v + CNT32_W'(1);
   endfunction

endpackage

// ===== rtl/core/bitc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bitc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bitc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitc_div
// Restoring divider, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module bitc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bitc_pkg::COORD_W-1:0]  dividend,
   input  logic [bitc_pkg::BW_W-1:0]     divisor,
   output logic                          done,
   output logic [bitc_pkg::BW_W-1:0]     rem
);
   import bitc_pkg::*;

   localparam int STEPS_W = $clog2(COORD_W + 1);

   logic [COORD_W-1:0] q_ff, q_in;
   logic [BW_W-1:0]    r_ff, r_in;
   logic [BW_W-1:0]    d_ff, d_in;
   logic [STEPS_W-1:0] n_ff, n_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [BW_W:0]      r_sh;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      n_in    = n_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      r_sh    = {r_ff, q_ff[COORD_W-1]};
      if (start) begin
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
         n_in   = STEPS_W'(COORD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in = {q_ff[COORD_W-2:0], 1'b0};
         if (r_sh >= {1'b0, d_ff}) begin
            r_in = BW_W'(r_sh - {1'b0, d_ff});
         end else begin
            r_in = BW_W'(r_sh);
         end
         n_in = n_ff - STEPS_W'(1);
         if (n_ff == STEPS_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         n_ff    <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         n_ff    <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign rem  = r_ff;

endmodule

// ===== rtl/core/bitc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitc_cell
// One bank of regions: scans its entries against the query, keeps a local
// best match and merges the best handed in from its neighbor.
// ----------------------------------------------------------------------------
module bitc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bitc_pkg::CELL_W-1:0]   cell_id,
   input  bitc_pkg::ctl_type             ctl,
   input  bitc_pkg::query_type           query,
   input  bitc_pkg::best_type            chain_in,
   output bitc_pkg::best_type            chain_out,
   output bitc_pkg::count_type           count_rd
);
   import bitc_pkg::*;

   region_type         region_q;
   count_type          count_q;
   logic               sel;
   logic               rd_v_ff;
   logic [BANK_AW-1:0] addr_ff;
   best_type           cand_ff, cand_in;
   best_type           best_ff, best_in;
   logic               match;
   logic [COORD_W+1:0] f33, l33, lo33;

   assign sel = (ctl.wcell == cell_id);

   bitc_ram #(.WIDTH($bits(region_type)), .DEPTH(BANK_DEPTH)) u_region_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_region && sel),
      .wr_addr (ctl.waddr),
      .wr_data (ctl.region_wdata),
      .rd_addr (ctl.raddr),
      .rd_data (region_q)
   );

   bitc_ram #(.WIDTH($bits(count_type)), .DEPTH(BANK_DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_count && (ctl.wr_all || sel)),
      .wr_addr (ctl.waddr),
      .wr_data (ctl.count_wdata),
      .rd_addr (ctl.raddr),
      .rd_data (count_q)
   );

   always_comb begin
      f33   = {2'b00, region_q.first};
      l33   = {2'b00, region_q.last};
      lo33  = {2'b00, query.lo};
      match = count_q.valid && (region_q.seq == query.chrom) &&
              (region_q.first <= query.c) && (query.c <= region_q.last) &&
              (((f33 >= lo33) && (f33 <= query.hi)) ||
               ((l33 >= lo33) && (l33 <= query.hi)));
      cand_in.found = rd_v_ff && match;
      cand_in.first = region_q.first;
      cand_in.last  = region_q.last;
      cand_in.slot  = SLOT_W'({cell_id, addr_ff});
      cand_in.hits  = count_q.hits;
      if (ctl.clr_best) begin
         best_in = '0;
      end else if (ctl.shift) begin
         best_in = pick(chain_in, best_ff);
      end else begin
         best_in = pick(cand_ff, best_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         cand_ff <= '0;
         best_ff <= '0;
      end else begin
         rd_v_ff <= ctl.rd_en;
         cand_ff <= cand_in;
         best_ff <= best_in;
      end
      addr_ff <= ctl.raddr;
   end

   assign chain_out = best_ff;
   assign count_rd  = count_q;

endmodule

// ===== rtl/core/binned_interval_tag_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_interval_tag_counter_unit
// Region table with per-region saturating tag counts, searched by a chain of
// bank cells.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel carries a load, count or read transaction; rsp_ returns one
//  result transaction for each. csr_ is an APB port holding bin_width at
//  byte address 0.
//  A count passes through the remainder divider, the scan of each cell's
//  bank at one entry a cycle, and the merge of the cells' best matches
//  along the chain. The table holds 1024 slots in 8 cells.
//  One transaction is worked on at a time; the next is taken while a
//  finished result still sits in the output register.
//  After reset the count memories are cleared while req_stall is held
//  high; configuration writes are taken anyway.
//  When the receiver stalls, the result holds in the output register and
//  at most one further transaction completes behind it.
// ----------------------------------------------------------------------------
module binned_interval_tag_counter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bitc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bitc_pkg::rsp_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bitc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bitc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bitc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import bitc_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MID, S_DIVGO, S_DIV, S_BOUND, S_SCAN, S_DRAIN,
      S_REDUCE, S_UPDATE, S_READ1, S_READ2, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   req_type            item_ff, item_in;
   logic [COORD_W-1:0] c_ff, c_in;
   query_type          query_ff, query_in;
   logic [CNT32_W-1:0] total_ff, total_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BW_W-1:0]    bw_ff, bw_in;
   logic [BW_W-1:0]    bw_eff;
   logic               accept;
   logic               in_range;
   logic               div_start, div_done;
   logic [BW_W-1:0]    div_rem;
   ctl_type            ctl;
   best_type           chain [NCELL+1];
   count_type          cnt_rd [NCELL];
   best_type           win;
   logic [CNT32_W-1:0] win_hits;

   assign bw_eff     = (bw_ff == '0) ? BW_W'(1) : bw_ff;
   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DW'(bw_ff);
   assign in_range   = ({1'b0, item_ff.slot} < (SLOT_W + 1)'(TABLE_DEPTH));
   assign div_start  = (state_ff == S_DIVGO);
   assign win        = chain[NCELL];
   assign win_hits   = sat_inc(win.hits);

   bitc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (c_ff),
      .divisor  (bw_eff),
      .done     (div_done),
      .rem      (div_rem)
   );

   assign chain[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      bitc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CELL_W'(k)),
         .ctl       (ctl),
         .query     (query_ff),
         .chain_in  (chain[k]),
         .chain_out (chain[k+1]),
         .count_rd  (cnt_rd[k])
      );
   end

   always_comb begin
      ctl          = '0;
      ctl.raddr    = cnt_ff[BANK_AW-1:0];
      ctl.region_wdata.seq   = req_data.chrom;
      ctl.region_wdata.first = req_data.start_req;
      ctl.region_wdata.last  = req_data.stop;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.wr_count = 1'b1;
            ctl.wr_all   = 1'b1;
            ctl.waddr    = cnt_ff[BANK_AW-1:0];
         end
         S_IDLE: begin
            ctl.wcell = req_data.slot[BANK_AW +: CELL_W];
            ctl.waddr = req_data.slot[BANK_AW-1:0];
            ctl.count_wdata.valid = 1'b1;
            if (accept && (req_data.func == FUNC_LOAD) &&
                ({1'b0, req_data.slot} < (SLOT_W + 1)'(TABLE_DEPTH))) begin
               ctl.wr_region = 1'b1;
               ctl.wr_count  = 1'b1;
            end
         end
         S_BOUND:  ctl.clr_best = 1'b1;
         S_SCAN:   ctl.rd_en = 1'b1;
         S_REDUCE: ctl.shift = 1'b1;
         S_UPDATE: begin
            ctl.wr_count    = win.found;
            ctl.wcell       = win.slot[BANK_AW +: CELL_W];
            ctl.waddr       = win.slot[BANK_AW-1:0];
            ctl.count_wdata = {1'b1, win_hits};
         end
         S_READ1: begin
            ctl.rd_en = 1'b1;
            ctl.raddr = item_ff.slot[BANK_AW-1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      c_in         = c_ff;
      query_in     = query_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      bw_in        = bw_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == '0)) begin
         bw_in = csr_pwdata[BW_W-1:0];
      end

      unique case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(BANK_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               item_in = req_data;
               unique case (req_data.func)
                  FUNC_LOAD: begin
                     res_in   = {1'b0, req_data.slot, {CNT32_W{1'b0}}, total_ff};
                     state_in = S_OUT;
                  end
                  FUNC_COUNT: begin
                     total_in = sat_inc(total_ff);
                     state_in = S_MID;
                  end
                  FUNC_READ: state_in = S_READ1;
                  default: begin
                     res_in   = {1'b0, {SLOT_W{1'b0}}, {CNT32_W{1'b0}}, total_ff};
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_MID: begin
            if (item_ff.stop >= item_ff.start_req) begin
               c_in = item_ff.start_req + ((item_ff.stop - item_ff.start_req) >> 1);
            end else begin
               c_in = item_ff.start_req - ((item_ff.start_req - item_ff.stop) >> 1);
            end
            state_in = S_DIVGO;
         end
         S_DIVGO: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               query_in.chrom = item_ff.chrom;
               query_in.c     = c_ff;
               query_in.lo    = c_ff - COORD_W'(div_rem);
               state_in       = S_BOUND;
            end
         end
         S_BOUND: begin
            query_in.hi = {2'b00, query_ff.lo} + (COORD_W + 2)'(bw_eff) -
                          (COORD_W + 2)'(1);
            cnt_in      = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(BANK_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               cnt_in   = '0;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(NCELL - 1)) begin
               cnt_in   = '0;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (win.found) begin
               res_in = {1'b1, win.slot, win_hits, total_ff};
            end else begin
               res_in = {1'b0, {SLOT_W{1'b0}}, {CNT32_W{1'b0}}, total_ff};
            end
            state_in = S_OUT;
         end
         S_READ1: state_in = S_READ2;
         S_READ2: begin
            res_in = {1'b0, item_ff.slot,
                      in_range ? cnt_rd[item_ff.slot[BANK_AW +: CELL_W]].hits
                               : {CNT32_W{1'b0}},
                      total_ff};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         total_ff     <= '0;
         bw_ff        <= BW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         bw_ff        <= bw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff  <= item_in;
      c_ff     <= c_in;
      query_ff <= query_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/binned_interval_tag_counter_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_interval_tag_counter_unit_checker
// Watches the request and response channels and predicts each response
// from its own copy of the region table. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module binned_interval_tag_counter_unit_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  bitc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  bitc_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [bitc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bitc_pkg::CSR_DW-1:0] csr_pwdata,
   output int                fail_count,
   output int                pending
);
   import bitc_pkg::*;

   logic [SEQ_W-1:0]   seq_tab   [TABLE_DEPTH];
   logic [COORD_W-1:0] first_tab [TABLE_DEPTH];
   logic [COORD_W-1:0] last_tab  [TABLE_DEPTH];
   logic               valid_tab [TABLE_DEPTH];
   logic [31:0]        hits_tab  [TABLE_DEPTH];
   logic [31:0]        tags_seen;
   logic [BW_W-1:0]    bin_span;
   rsp_type            exp_fifo  [16];
   int                 wr_cnt;
   int                 rd_cnt;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic rsp_type tally(input req_type r);
      rsp_type o;
      logic [31:0] bw, c, cb, f, l;
      int best;
      o = '0;
      bw = (bin_span == 0) ? 32'd1 : 32'(bin_span);
      best = -1;
      case (r.func)
         FUNC_LOAD: begin
            seq_tab[r.slot] = r.chrom;
            first_tab[r.slot] = r.start_req;
            last_tab[r.slot] = r.stop;
            valid_tab[r.slot] = 1'b1;
            hits_tab[r.slot] = '0;
            o.hit_slot = r.slot;
         end
         FUNC_COUNT: begin
            if (r.stop >= r.start_req) c = r.start_req + (r.stop - r.start_req) / 2;
            else c = r.start_req - (r.start_req - r.stop) / 2;
            cb = c / bw;
            tags_seen = bump(tags_seen);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               f = first_tab[i];
               l = last_tab[i];
               if (valid_tab[i] && seq_tab[i] == r.chrom && (f / bw == cb || l / bw == cb)
                   && f <= c && l >= c) begin
                  if (best < 0 || f < first_tab[best] ||
                      (f == first_tab[best] && l < last_tab[best])) best = i;
               end
            end
            if (best >= 0) begin
               hits_tab[best] = bump(hits_tab[best]);
               o.hit = 1'b1;
               o.hit_slot = SLOT_W'(best);
               o.region_count = hits_tab[best];
            end
         end
         FUNC_READ: begin
            o.hit_slot = r.slot;
            o.region_count = hits_tab[r.slot];
         end
         default: ;
      endcase
      o.tag_total = tags_seen;
      return o;
   endfunction

   assign pending = wr_cnt - rd_cnt;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            valid_tab[i] = 1'b0;
            hits_tab[i] = '0;
            seq_tab[i] = '0;
            first_tab[i] = '0;
            last_tab[i] = '0;
         end
         tags_seen = '0;
         bin_span = BW_RESET;
         fail_count = 0;
         wr_cnt = 0;
         rd_cnt = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == '0)
            bin_span = csr_pwdata[BW_W-1:0];
         if (req_valid && !req_stall) begin
            if (wr_cnt - rd_cnt >= 16) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) $display("too many transactions in flight");
            end
            exp_fifo[4'(wr_cnt)] = tally(req_data);
            wr_cnt = wr_cnt + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (wr_cnt == rd_cnt) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) $display("unexpected response %h", rsp_data);
            end else begin
               want = exp_fifo[4'(rd_cnt)];
               rd_cnt = rd_cnt + 1;
               if (want !== rsp_data) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("mismatch: expected hit=%0d slot=%0d cnt=%0d tot=%0d, actual hit=%0d slot=%0d cnt=%0d tot=%0d",
                        want.hit, want.hit_slot, want.region_count, want.tag_total,
                        rsp_data.hit, rsp_data.hit_slot, rsp_data.region_count,
                        rsp_data.tag_total);
               end
            end
         end
      end
   end
endmodule

// ===== bench/binned_interval_tag_counter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_interval_tag_counter_unit_tb
// Drives loads, counts and reads through several bin widths and idle
// patterns; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module binned_interval_tag_counter_unit_tb;
   import bitc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending;
   int send_idle = 0, recv_idle = 0;

   logic [SEQ_W-1:0]   ld_chrom [64];
   logic [COORD_W-1:0] ld_first [64];
   logic [COORD_W-1:0] ld_last  [64];

   always #6 clock = ~clock;

   binned_interval_tag_counter_unit u_top (.*);

   binned_interval_tag_counter_unit_checker u_chk (.*);

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   task automatic csr_write(input logic [31:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= '0; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // valid stays up after acceptance; drain, or an idle gap in the next send, lowers it
   task automatic send(input req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic req_type make_req(input logic [1:0] f, input logic [7:0] ch,
                                        input logic [30:0] a, input logic [30:0] b,
                                        input logic [9:0] s);
      req_type r;
      r.func = f; r.chrom = ch; r.start_req = a; r.stop = b; r.slot = s;
      return r;
   endfunction

   task automatic random_phase(input int n, input logic [31:0] span);
      req_type r;
      int k;
      logic [30:0] a, b;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(63);
         case ($urandom_range(9))
            0, 1: begin
               a = 31'($urandom_range(3 * span));
               b = a + 31'($urandom_range(2 * span));
               if ($urandom_range(15) == 0) b = 31'($urandom);
               if ($urandom_range(15) == 0) a = 31'($urandom);
               ld_chrom[k] = 8'($urandom_range(3)); ld_first[k] = a; ld_last[k] = b;
               r = make_req(FUNC_LOAD, ld_chrom[k], a, b, 10'(k));
            end
            2: r = make_req(FUNC_READ, 8'($urandom), 31'($urandom), 31'($urandom),
                            ($urandom_range(3) == 0) ? 10'($urandom) : 10'(k));
            3: r = make_req(2'($urandom), 8'($urandom), 31'($urandom), 31'($urandom),
                            10'($urandom));
            default: begin
               a = ld_first[k] + 31'($urandom_range(span));
               b = a + 31'($urandom_range(span / 2 + 1));
               if ($urandom_range(7) == 0) b = a - 31'($urandom_range(span));
               r = make_req(FUNC_COUNT,
                            ($urandom_range(9) == 0) ? 8'($urandom) : ld_chrom[k],
                            a, b, 10'($urandom));
            end
         endcase
         if (r.func == FUNC_LOAD && i % 3 == 0) r.slot = 10'($urandom);
         send(r);
      end
   endtask

   initial begin
      #50_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      for (int i = 0; i < 64; i++) begin
         ld_chrom[i] = 0; ld_first[i] = 0; ld_last[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(make_req(FUNC_LOAD, 8'd0, 31'd0, 31'h7FFF_FFFF, 10'd1023));
      send(make_req(FUNC_LOAD, 8'd0, 31'd0, 31'h7FFF_FFFF, 10'd5));
      send(make_req(FUNC_LOAD, 8'd255, 31'd100, 31'd200, 10'd0));
      send(make_req(FUNC_LOAD, 8'd255, 31'd100, 31'd200, 10'd7));
      send(make_req(FUNC_LOAD, 8'd255, 31'd300, 31'd100, 10'd8));
      send(make_req(FUNC_LOAD, 8'd3, 31'd5000, 31'd50000, 10'd9));
      send(make_req(FUNC_COUNT, 8'd255, 31'd150, 31'd150, 10'd0));
      send(make_req(FUNC_COUNT, 8'd255, 31'd300, 31'd100, 10'd0));
      send(make_req(FUNC_COUNT, 8'd3, 31'd25000, 31'd25000, 10'd0));
      send(make_req(FUNC_COUNT, 8'd3, 31'd5000, 31'd5001, 10'd0));
      send(make_req(FUNC_COUNT, 8'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 10'h3FF));
      send(make_req(FUNC_COUNT, 8'd0, 31'd0, 31'd0, 10'd0));
      send(make_req(FUNC_READ, 8'd0, 31'd0, 31'd0, 10'd1023));
      send(make_req(FUNC_READ, 8'd0, 31'd0, 31'd0, 10'd0));
      send(make_req(FUNC_READ, 8'd0, 31'd0, 31'd0, 10'd7));
      send(make_req(2'd3, 8'hFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 10'h3FF));
      drain();
      csr_write(32'd0);
      send(make_req(FUNC_COUNT, 8'd3, 31'd25000, 31'd25000, 10'd0));
      drain();
      csr_write(32'd1048576);
      send(make_req(FUNC_COUNT, 8'd3, 31'd25000, 31'd25000, 10'd0));
      drain();
      csr_write(32'd10000);
      random_phase(350, 32'd10000);
      drain();
      send_idle = 79;
      csr_write(32'd1);
      random_phase(350, 32'd8);
      drain();
      send_idle = 0; recv_idle = 79;
      csr_write(32'd1048576);
      random_phase(350, 32'd1048576);
      drain();
      send_idle = 12; recv_idle = 12;
      csr_write(32'd333);
      random_phase(350, 32'd1000);
      drain();
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
